### design/fpc_pkg.sv
// ----------------------------------------------------------------------------
// fpc_pkg: shared types and constants
// Constants and types for the first-person camera pose keeper.
// ----------------------------------------------------------------------------
`default_nettype none

package fpc_pkg;

  // shared multiplier operand and product widths
  localparam int MUL_W  = 33;
  localparam int PROD_W = 2 * MUL_W;

  // sine polynomial coefficients, Q30
  localparam logic [30:0] POLY_A   = 31'd1686629713;
  localparam logic [30:0] POLY_B   = 31'd688904866;
  localparam logic [30:0] POLY_C   = 31'd76016977;
  localparam logic [32:0] ONE_Q30  = 33'd1073741824;
  localparam logic [32:0] SIN_FULL = 33'd32767;

  // register reset values and the y floor
  localparam logic [30:0] BOUND_RST = 31'd4194304;
  localparam logic [30:0] EYE_RST   = 31'd65536;
  localparam logic signed [31:0] POS_Y_RST = 32'sd65536;
  localparam logic signed [32:0] Y_MIN     = 33'sd65536;

  localparam logic OP_MOVE = 1'b0;
  localparam logic OP_TURN = 1'b1;

  typedef enum logic [1:0] {
    REG_BOUND_X = 2'd0,
    REG_BOUND_Y = 2'd1,
    REG_BOUND_Z = 2'd2,
    REG_EYE     = 2'd3
  } reg_idx_t;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_PREP = 6'b000010,
    ST_TRIG = 6'b000100,
    ST_MOVE = 6'b001000,
    ST_EYE  = 6'b010000,
    ST_OUT  = 6'b100000
  } state_t;

endpackage

`default_nettype wire

### design/fpc_if.sv
// ----------------------------------------------------------------------------
// fpc_if: camera channel interfaces
// Valid/ready channels for camera commands and pose results.
// ----------------------------------------------------------------------------
`default_nettype none

interface fpc_in_if;
  logic               valid;
  logic               ready;
  logic               op;
  logic signed [31:0] move_front;
  logic signed [31:0] move_left;
  logic signed [31:0] move_up;
  logic signed [15:0] raise;
  logic signed [15:0] yaw_delta;

  modport source (output valid, op, move_front, move_left, move_up, raise, yaw_delta,
                  input ready);
  modport sink   (input valid, op, move_front, move_left, move_up, raise, yaw_delta,
                  output ready);
endinterface

interface fpc_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [31:0] look_x;
  logic signed [31:0] look_y;
  logic signed [31:0] look_z;
  logic signed [15:0] head_x;
  logic signed [15:0] head_y;
  logic signed [15:0] head_z;

  modport source (output valid, pos_x, pos_y, pos_z, look_x, look_y, look_z,
                  head_x, head_y, head_z, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, look_x, look_y, look_z,
                  head_x, head_y, head_z, output ready);
endinterface

`default_nettype wire

### design/first_person_camera_update_unit.sv
// ----------------------------------------------------------------------------
// first_person_camera_update_unit: first-person camera pose keeper
// Applies move/turn commands to the pose and returns position, look-at
// point and head vector, all through one shared multiplier.
// ----------------------------------------------------------------------------
//   channel  | dir | handshake              | payload
//   in_if    | in  | valid/ready            | op, move_*, raise, yaw_delta
//   out_if   | out | valid/ready            | pos_*, look_*, head_*
//   apb      | in  | psel/penable, pready=1 | bound_x/y/z, eye_distance
//
// One transaction at a time; the result then waits on out_if.ready. All
// products go through the single multiplier: five per sine (four sines),
// four for the move, seven for the eye and head vectors, each issued and
// then consumed from the multiplier's output register.
// Synchronous active-low reset; no clearing pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module first_person_camera_update_unit #(
  parameter int ANGLE_BITS       = 16,
  parameter int TRIG_TABLE_DEPTH = 1024  // power of two
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  fpc_in_if.sink           in_if,
  fpc_out_if.source        out_if,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  localparam int AB = ANGLE_BITS;
  localparam int LD = $clog2(TRIG_TABLE_DEPTH);
  localparam int PW = ((AB > 16) ? AB : 16) + 2;
  localparam logic [AB-1:0] ANG_QUARTER = {2'b01, {(AB-2){1'b0}}};
  localparam logic [AB-1:0] ANG_HALF    = {2'b10, {(AB-2){1'b0}}};
  localparam logic signed [fpc_pkg::PROD_W-1:0] RND30 = fpc_pkg::PROD_W'(64'sd536870912);
  localparam logic signed [fpc_pkg::PROD_W-1:0] RND15 = fpc_pkg::PROD_W'(64'sd16384);
  localparam logic signed [49:0] ACC_RND = 50'sd16384;
  localparam logic signed [33:0] S32_MAX = 34'sd2147483647;
  localparam logic signed [33:0] S32_MIN = -34'sd2147483648;

  // ---------------- configuration ----------------
  logic [30:0] bound_x_r, bound_y_r, bound_z_r, eye_r;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bound_x_r <= fpc_pkg::BOUND_RST;
      bound_y_r <= fpc_pkg::BOUND_RST;
      bound_z_r <= fpc_pkg::BOUND_RST;
      eye_r     <= fpc_pkg::EYE_RST;
    end else if (cfg_wr) begin
      unique case (fpc_pkg::reg_idx_t'(paddr[3:2]))
        fpc_pkg::REG_BOUND_X: bound_x_r <= pwdata[30:0];
        fpc_pkg::REG_BOUND_Y: bound_y_r <= pwdata[30:0];
        fpc_pkg::REG_BOUND_Z: bound_z_r <= pwdata[30:0];
        fpc_pkg::REG_EYE:     eye_r     <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (fpc_pkg::reg_idx_t'(paddr[3:2]))
      fpc_pkg::REG_BOUND_X: prdata = {1'b0, bound_x_r};
      fpc_pkg::REG_BOUND_Y: prdata = {1'b0, bound_y_r};
      fpc_pkg::REG_BOUND_Z: prdata = {1'b0, bound_z_r};
      fpc_pkg::REG_EYE:     prdata = {1'b0, eye_r};
      default:              prdata = '0;
    endcase
  end

  // ---------------- registers ----------------
  fpc_pkg::state_t state_r, state_nxt;
  logic [3:0] step_r, step_nxt;
  logic [1:0] tidx_r, tidx_nxt;

  logic               op_r;
  logic signed [31:0] front_r, left_r, up_r;
  logic signed [15:0] raise_r, yawd_r;

  logic signed [31:0] pos_x_r, pos_y_r, pos_z_r;
  logic signed [31:0] pos_x_nxt, pos_y_nxt, pos_z_nxt;
  logic [AB-1:0]      yaw_r, pitch_r, yaw_nxt, pitch_nxt;

  logic signed [15:0] sy_r, cy_r, sp_r, cp_r, sy_nxt, cy_nxt, sp_nxt, cp_nxt;
  logic [30:0]        t2_r, t2_nxt;
  logic signed [32:0] w_r, w_nxt;
  logic signed [49:0] acc_r, acc_nxt;
  logic signed [32:0] ex_r, ey_r, ez_r, ex_nxt, ey_nxt, ez_nxt;
  logic signed [15:0] hx_r, hz_r, hx_nxt, hz_nxt;
  logic signed [31:0] lx_r, ly_r, lz_r, lx_nxt, ly_nxt, lz_nxt;

  // ---------------- sine argument ----------------
  logic [AB-1:0]      ang_base, ang;
  logic [1:0]         quad;
  logic [AB-2:0]      rm;
  logic [AB-2+LD:0]   rk;
  logic [LD:0]        kidx;
  logic [30:0]        t_val;

  always_comb begin
    ang_base = tidx_r[1] ? pitch_r : yaw_r;
    ang      = ang_base + (tidx_r[0] ? ANG_QUARTER : '0);
    quad     = ang[AB-1:AB-2];
    rm       = quad[0] ? (ANG_QUARTER[AB-2:0] - {1'b0, ang[AB-3:0]})
                       : {1'b0, ang[AB-3:0]};
    rk       = {rm, {LD{1'b0}}};
    kidx     = rk[AB-2+LD:AB-2];
    t_val    = {kidx, {(30-LD){1'b0}}};
  end

  // ---------------- shared multiplier ----------------
  logic signed [fpc_pkg::MUL_W-1:0]  ma, mb;
  logic signed [fpc_pkg::PROD_W-1:0] prod;
  logic signed [fpc_pkg::MUL_W-1:0]  t_op, t2_op, eye_op;

  assign t_op   = $signed({2'b00, t_val});
  assign t2_op  = $signed({2'b00, t2_r});
  assign eye_op = $signed({2'b00, eye_r});

  always_comb begin
    ma = '0;
    mb = '0;
    case (state_r)
      fpc_pkg::ST_TRIG: begin
        case (step_r)
          4'd0: begin ma = t_op;  mb = t_op; end
          4'd2: begin ma = t2_op; mb = $signed({2'b00, fpc_pkg::POLY_C}); end
          4'd4: begin ma = t2_op; mb = w_r; end
          4'd6: begin ma = t_op;  mb = w_r; end
          4'd8: begin ma = w_r;   mb = $signed(fpc_pkg::SIN_FULL); end
          default: ;
        endcase
      end
      fpc_pkg::ST_MOVE: begin
        case (step_r)
          4'd0: begin ma = 33'(cy_r); mb = 33'(front_r); end
          4'd2: begin ma = 33'(sy_r); mb = 33'(left_r);  end
          4'd5: begin ma = 33'(sy_r); mb = 33'(front_r); end
          4'd7: begin ma = 33'(cy_r); mb = 33'(left_r);  end
          default: ;
        endcase
      end
      fpc_pkg::ST_EYE: begin
        case (step_r)
          4'd0:  begin ma = 33'(cy_r);  mb = 33'(sp_r); end
          4'd2:  begin ma = w_r;        mb = eye_op;    end
          4'd4:  begin ma = 33'(sy_r);  mb = 33'(sp_r); end
          4'd6:  begin ma = w_r;        mb = eye_op;    end
          4'd8:  begin ma = 33'(cp_r);  mb = eye_op;    end
          4'd10: begin ma = -33'(sy_r); mb = 33'(cp_r); end
          4'd12: begin ma = -33'(cy_r); mb = 33'(cp_r); end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  fpc_mul u_mul (
    .clk (clk),
    .a_i (ma),
    .b_i (mb),
    .p_o (prod)
  );

  // ---------------- datapath helpers ----------------
  logic signed [PW-1:0]  np;
  logic [32:0]           s_q30;
  logic [15:0]           sin_mag;
  logic signed [15:0]    sin_val;
  logic signed [fpc_pkg::PROD_W-1:0] r30, r15;
  logic signed [49:0]    dsum;
  logic signed [34:0]    dstep;
  logic signed [35:0]    vpos, hb;
  logic [30:0]           bsel;
  logic signed [32:0]    ny;
  logic signed [33:0]    sx, sy_sum, sz;

  assign r30     = prod + RND30;
  assign r15     = prod + RND15;
  assign s_q30   = prod[62:30];
  assign sin_mag = r30[45:30];
  assign sin_val = quad[1] ? -$signed(sin_mag) : $signed(sin_mag);
  assign dsum    = acc_r + ACC_RND;
  assign dstep   = dsum[49:15];
  assign bsel    = (step_r == 4'd4) ? bound_z_r : bound_x_r;
  assign hb      = $signed({6'b0, bsel[30:1]});
  assign vpos    = ((step_r == 4'd4) ? 36'(pos_z_r) : 36'(pos_x_r)) + 36'(dstep);
  assign ny      = 33'(pos_y_r) + 33'(up_r);
  assign np      = PW'($signed({1'b0, pitch_r})) - PW'(raise_r);
  assign sx      = 34'(pos_x_r) + 34'(ex_r);
  assign sy_sum  = 34'(pos_y_r) + 34'(ey_r);
  assign sz      = 34'(pos_z_r) + 34'(ez_r);

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    if (v > S32_MAX) return 32'sh7fffffff;
    if (v < S32_MIN) return 32'sh80000000;
    return v[31:0];
  endfunction

  // ---------------- sequencer ----------------
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    tidx_nxt  = tidx_r;
    pos_x_nxt = pos_x_r;
    pos_y_nxt = pos_y_r;
    pos_z_nxt = pos_z_r;
    yaw_nxt   = yaw_r;
    pitch_nxt = pitch_r;
    sy_nxt = sy_r; cy_nxt = cy_r; sp_nxt = sp_r; cp_nxt = cp_r;
    t2_nxt = t2_r;
    w_nxt  = w_r;
    acc_nxt = acc_r;
    ex_nxt = ex_r; ey_nxt = ey_r; ez_nxt = ez_r;
    hx_nxt = hx_r; hz_nxt = hz_r;
    lx_nxt = lx_r; ly_nxt = ly_r; lz_nxt = lz_r;

    unique case (state_r)
      fpc_pkg::ST_IDLE: begin
        if (in_if.valid) state_nxt = fpc_pkg::ST_PREP;
      end
      fpc_pkg::ST_PREP: begin
        if (op_r == fpc_pkg::OP_TURN) begin
          if (np < 0) pitch_nxt = '0;
          else if (np > PW'($signed({1'b0, ANG_HALF}))) pitch_nxt = ANG_HALF;
          else pitch_nxt = np[AB-1:0];
          yaw_nxt = yaw_r + AB'(yawd_r);
        end
        state_nxt = fpc_pkg::ST_TRIG;
        step_nxt  = '0;
        tidx_nxt  = '0;
      end
      fpc_pkg::ST_TRIG: begin
        step_nxt = step_r + 4'd1;
        case (step_r)
          4'd1: t2_nxt = prod[60:30];
          4'd3: w_nxt = $signed({2'b00, fpc_pkg::POLY_B}) - $signed({2'b00, prod[60:30]});
          4'd5: w_nxt = $signed({2'b00, fpc_pkg::POLY_A}) - $signed({2'b00, prod[60:30]});
          4'd7: w_nxt = (s_q30 > fpc_pkg::ONE_Q30) ? $signed(fpc_pkg::ONE_Q30)
                                                     : $signed(s_q30);
          4'd9: begin
            case (tidx_r)
              2'd0:    sy_nxt = sin_val;
              2'd1:    cy_nxt = sin_val;
              2'd2:    sp_nxt = sin_val;
              default: cp_nxt = sin_val;
            endcase
            step_nxt = '0;
            tidx_nxt = tidx_r + 2'd1;
            if (tidx_r == 2'd3) begin
              state_nxt = (op_r == fpc_pkg::OP_MOVE) ? fpc_pkg::ST_MOVE : fpc_pkg::ST_EYE;
            end
          end
          default: ;
        endcase
      end
      fpc_pkg::ST_MOVE: begin
        step_nxt = step_r + 4'd1;
        case (step_r)
          4'd1, 4'd6: acc_nxt = 50'(prod);
          4'd3:       acc_nxt = acc_r - 50'(prod);
          4'd8:       acc_nxt = acc_r + 50'(prod);
          4'd4, 4'd9: begin
            // clamp to the centered box; z on the first pass, x on the second
            if (vpos < -hb) begin
              if (step_r == 4'd4) pos_z_nxt = 32'(-hb);
              else                pos_x_nxt = 32'(-hb);
            end else if (vpos > hb) begin
              if (step_r == 4'd4) pos_z_nxt = 32'(hb);
              else                pos_x_nxt = 32'(hb);
            end else begin
              if (step_r == 4'd4) pos_z_nxt = vpos[31:0];
              else                pos_x_nxt = vpos[31:0];
            end
            if (step_r == 4'd9) begin
              // ceiling first, then floor: a ceiling below the floor wins
              if ((ny > 33'($signed({1'b0, bound_y_r}))) ||
                  (fpc_pkg::Y_MIN > 33'($signed({1'b0, bound_y_r}))))
                pos_y_nxt = $signed({1'b0, bound_y_r});
              else if (ny < fpc_pkg::Y_MIN)
                pos_y_nxt = 32'(fpc_pkg::Y_MIN);
              else
                pos_y_nxt = ny[31:0];
              state_nxt = fpc_pkg::ST_EYE;
              step_nxt  = '0;
            end
          end
          default: ;
        endcase
      end
      fpc_pkg::ST_EYE: begin
        step_nxt = step_r + 4'd1;
        case (step_r)
          4'd1, 4'd5: w_nxt = prod[32:0];
          4'd3:  ez_nxt = r30[62:30];
          4'd7:  ex_nxt = r30[62:30];
          4'd9:  ey_nxt = r15[47:15];
          4'd11: hx_nxt = r15[30:15];
          4'd13: hz_nxt = r15[30:15];
          4'd14: begin
            lx_nxt = sat32(sx);
            ly_nxt = sat32(sy_sum);
            lz_nxt = sat32(sz);
            state_nxt = fpc_pkg::ST_OUT;
            step_nxt  = '0;
          end
          default: ;
        endcase
      end
      fpc_pkg::ST_OUT: begin
        if (out_if.ready) state_nxt = fpc_pkg::ST_IDLE;
      end
      default: state_nxt = fpc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fpc_pkg::ST_IDLE;
      step_r  <= '0;
      tidx_r  <= '0;
      pos_x_r <= '0;
      pos_y_r <= fpc_pkg::POS_Y_RST;
      pos_z_r <= '0;
      yaw_r   <= '0;
      pitch_r <= ANG_QUARTER;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      tidx_r  <= tidx_nxt;
      pos_x_r <= pos_x_nxt;
      pos_y_r <= pos_y_nxt;
      pos_z_r <= pos_z_nxt;
      yaw_r   <= yaw_nxt;
      pitch_r <= pitch_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      op_r    <= in_if.op;
      front_r <= in_if.move_front;
      left_r  <= in_if.move_left;
      up_r    <= in_if.move_up;
      raise_r <= in_if.raise;
      yawd_r  <= in_if.yaw_delta;
    end
    sy_r <= sy_nxt; cy_r <= cy_nxt; sp_r <= sp_nxt; cp_r <= cp_nxt;
    t2_r <= t2_nxt;
    w_r  <= w_nxt;
    acc_r <= acc_nxt;
    ex_r <= ex_nxt; ey_r <= ey_nxt; ez_r <= ez_nxt;
    hx_r <= hx_nxt; hz_r <= hz_nxt;
    lx_r <= lx_nxt; ly_r <= ly_nxt; lz_r <= lz_nxt;
  end

  // ---------------- ports ----------------
  assign in_if.ready   = (state_r == fpc_pkg::ST_IDLE);
  assign out_if.valid  = (state_r == fpc_pkg::ST_OUT);
  assign out_if.pos_x  = pos_x_r;
  assign out_if.pos_y  = pos_y_r;
  assign out_if.pos_z  = pos_z_r;
  assign out_if.look_x = lx_r;
  assign out_if.look_y = ly_r;
  assign out_if.look_z = lz_r;
  assign out_if.head_x = hx_r;
  assign out_if.head_y = sp_r;
  assign out_if.head_z = hz_r;

endmodule

`default_nettype wire

### design/fpc_mul.sv
// ----------------------------------------------------------------------------
// fpc_mul: shared registered multiplier
// Signed 33x33 multiply with the product registered for the next cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module fpc_mul (
  input  wire logic                               clk,
  input  wire logic signed [fpc_pkg::MUL_W-1:0]   a_i,
  input  wire logic signed [fpc_pkg::MUL_W-1:0]   b_i,
  output logic signed [fpc_pkg::PROD_W-1:0]       p_o
);

  logic signed [fpc_pkg::PROD_W-1:0] p_r;

  always_ff @(posedge clk) begin
    p_r <= a_i * b_i;
  end

  assign p_o = p_r;

endmodule

`default_nettype wire

### design/fpc_checker.sv
// ----------------------------------------------------------------------------
// fpc_checker: port-level checks for the camera pose keeper
// One transaction in flight at a time; results hold until taken.
// ----------------------------------------------------------------------------
`default_nettype none

module fpc_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic signed [31:0] out_pos_x,
  input wire logic               pready
);

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_valid && in_ready))
    else $error("input ready while a result is pending");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second transaction accepted while busy");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_pos_x)))
    else $error("stalled result dropped or changed");

  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready) |=> !out_valid)
    else $error("result repeated");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("pready low");

endmodule

bind first_person_camera_update_unit fpc_checker u_fpc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_if.valid),
  .in_ready  (in_if.ready),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .out_pos_x (out_if.pos_x),
  .pready    (pready)
);

`default_nettype wire
